FILE: rtl/core/keyed_order_table_assert.svh
`ifndef KEYED_ORDER_TABLE_ASSERT_SVH
`define KEYED_ORDER_TABLE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define KOT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_order_table check failed");

// next-cycle implication
`define KOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_order_table check failed");

`endif

FILE: rtl/core/kot_pkg.sv
package kot_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		REQ_INSERT    = 3'd0,
		REQ_DROP_OLD  = 3'd1,
		REQ_DROP_KEY  = 3'd2,
		REQ_DROP_ORD  = 3'd3,
		REQ_SET_ORD   = 3'd4,
		REQ_READ      = 3'd5
	} req_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [15:0] order;
		logic [15:0] node;
		logic [15:0] channel;
		logic [31:0] payload;
		logic [47:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/kot_entry_ram.sv
module kot_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/keyed_order_table.sv
// channel   ports                                          handshake
// request   req_type node_id channel_id order_number      start high, busy low
//           payload time_ms slot_index
// result    status affected out_valid out_order out_node  done strobe, one cycle
//           out_channel out_payload out_stamp
//
// every request scans all ENTRIES slots through the registered-read entry ram:
// busy stays high for the whole scan, done pulses in the cycle after the last busy cycle.
// a new transaction is taken in the cycle done is high, not while a scan is still running.
// arst_n clears the valid bits and control state; entry ram contents stay undefined.
// the receiver cannot stall: done flags each new result for exactly one cycle.
module keyed_order_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [15:0] node_id,
	input  logic [15:0] channel_id,
	input  logic [15:0] order_number,
	input  logic [31:0] payload,
	input  logic [47:0] time_ms,
	input  logic [3:0]  slot_index,
	output logic        done,
	output logic        status,
	output logic [kot_pkg::CNT_W-1:0] affected,
	output logic        out_valid,
	output logic [15:0] out_order,
	output logic [15:0] out_node,
	output logic [15:0] out_channel,
	output logic [31:0] out_payload,
	output logic [47:0] out_stamp
);

	import kot_pkg::*;

	state_t state_q, state_d;

	logic [2:0]  req_q;
	logic [15:0] node_q;
	logic [15:0] chan_q;
	logic [15:0] ord_q;
	logic [31:0] pay_q;
	logic [47:0] time_q;
	logic [3:0]  sidx_q;

	logic [IDX_W:0]   ptr_q;
	logic             proc_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [ENTRIES-1:0] valid_q, valid_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic   cap_valid_q;
	entry_t cap_q;

	logic accept, issue, last;
	logic cur_valid, key_hit, remove, set_hit, hit, free_now;
	logic fin_found, ins_ok, rd_hit;
	logic [IDX_W-1:0] fin_idx;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_entry, rd_entry;
	logic [ENTRY_W-1:0] rd_raw;

	kot_entry_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		busy   = 1'b0;
		accept = 1'b0;
		issue  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				accept = start;
			end
			ST_SCAN: begin
				busy  = 1'b1;
				issue = (ptr_q < (IDX_W+1)'(ENTRIES));
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign last = proc_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	// per-slot evaluation of the entry returned by the ram
	always_comb begin
		cur_valid = proc_s1 && valid_q[idx_s1];
		key_hit   = cur_valid && (rd_entry.node == node_q) && (rd_entry.channel == chan_q);
		remove    = 1'b0;
		set_hit   = 1'b0;
		rd_hit    = 1'b0;
		case (req_q)
			REQ_INSERT,
			REQ_DROP_KEY: remove  = key_hit;
			REQ_DROP_OLD: remove  = cur_valid && (rd_entry.stamp < time_q);
			REQ_DROP_ORD: remove  = cur_valid && (rd_entry.order == ord_q);
			REQ_SET_ORD:  set_hit = key_hit;
			REQ_READ:     rd_hit  = cur_valid && (32'(idx_s1) == 32'(sidx_q));
			default:      remove  = 1'b0;
		endcase
		hit     = remove || set_hit;
		count_d = (hit && (count_q != CNT_MAX)) ? count_q + CNT_W'(1) : count_q;

		free_now  = proc_s1 && (!valid_q[idx_s1] || remove);
		fin_found = free_found_q || free_now;
		fin_idx   = free_found_q ? free_idx_q : idx_s1;
		ins_ok    = last && (req_q == REQ_INSERT) && fin_found;

		valid_d = valid_q;
		if (remove) valid_d[idx_s1] = 1'b0;
		if (ins_ok) valid_d[fin_idx] = 1'b1;

		wr_en    = set_hit || ins_ok;
		wr_addr  = ins_ok ? fin_idx : idx_s1;
		wr_entry = rd_entry;
		if (ins_ok) begin
			wr_entry.order   = '0;
			wr_entry.node    = node_q;
			wr_entry.channel = chan_q;
			wr_entry.payload = pay_q;
			wr_entry.stamp   = time_q;
		end else begin
			wr_entry.order = ord_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			proc_s1      <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			free_found_q <= 1'b0;
			cap_valid_q  <= 1'b0;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			proc_s1 <= issue;
			done    <= last;
			valid_q <= valid_d;
			if (accept) begin
				ptr_q        <= '0;
				count_q      <= '0;
				free_found_q <= 1'b0;
				cap_valid_q  <= 1'b0;
			end else begin
				if (issue) ptr_q <= ptr_q + (IDX_W+1)'(1);
				if (proc_s1) begin
					count_q <= count_d;
					if (free_now && !free_found_q) free_found_q <= 1'b1;
					if (rd_hit) cap_valid_q <= 1'b1;
				end
			end
		end
	end

	// request, capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			node_q <= node_id;
			chan_q <= channel_id;
			ord_q  <= order_number;
			pay_q  <= payload;
			time_q <= time_ms;
			sidx_q <= slot_index;
			cap_q  <= '0;
		end else if (rd_hit) begin
			cap_q <= rd_entry;
		end
		if (issue) idx_s1 <= ptr_q[IDX_W-1:0];
		if (free_now && !free_found_q) free_idx_q <= idx_s1;
		if (last) begin
			status      <= (req_q == REQ_INSERT) && !fin_found;
			affected    <= count_d;
			out_valid   <= cap_valid_q || rd_hit;
			out_order   <= rd_hit ? rd_entry.order   : cap_q.order;
			out_node    <= rd_hit ? rd_entry.node    : cap_q.node;
			out_channel <= rd_hit ? rd_entry.channel : cap_q.channel;
			out_payload <= rd_hit ? rd_entry.payload : cap_q.payload;
			out_stamp   <= rd_hit ? rd_entry.stamp   : cap_q.stamp;
		end
	end

endmodule

FILE: rtl/core/kot_checker.sv
`include "keyed_order_table_assert.svh"

module kot_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      status,
	input logic [kot_pkg::CNT_W-1:0] affected,
	input logic                      out_valid
);

	import kot_pkg::*;

	`KOT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`KOT_ASSERT_NOW(a_done_idle, done, !busy)
	`KOT_ASSERT_NOW(a_busy_end_done, $fell(busy), done)
	`KOT_ASSERT_NEXT(a_done_single, done, !done)
	`KOT_ASSERT_NOW(a_full_clean, done && (status || out_valid), affected == '0)

endmodule

bind keyed_order_table kot_checker u_kot_checker (.*);
